### hw/rtl/ski_pkg.sv
package ski_pkg;

  localparam int NUM_CH    = 8;
  localparam int ANGLE_W   = 8;
  localparam int OFFS_W    = 7;
  localparam int DUR_W     = 11;
  localparam int TICK_W    = 7;
  localparam int DVS_W     = 10;
  localparam int SRV_IDX_W = 3;
  localparam int CFG_IDX_W = 4;
  localparam int GOAL_W    = 10;

  localparam int ANGLE_MAX = 180;

  localparam int TICK_PERIOD_MS_DEF = 20;
  localparam int SERVO_COUNT_DEF    = 8;
  localparam int MAX_TICKS_DEF      = 64;

  localparam logic [NUM_CH-1:0][ANGLE_W-1:0] RESET_ANGLES = {
    8'd135, 8'd45, 8'd135, 8'd45, 8'd45, 8'd135, 8'd45, 8'd135
  };

  typedef struct packed {
    logic               load;
    logic               step;
    logic               neg;
    logic [ANGLE_W-1:0] q0;
    logic [TICK_W-1:0]  r0;
    logic [TICK_W-1:0]  n;
  } lane_ctl_t;

endpackage

### hw/rtl/ski_serdiv.sv
module ski_serdiv (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ski_pkg::DUR_W-1:0] dividend,
  input  logic [ski_pkg::DVS_W-1:0] divisor,
  output logic                     done,
  output logic [ski_pkg::DUR_W-1:0] quotient,
  output logic [ski_pkg::DVS_W-1:0] remainder
);
  import ski_pkg::*;

  localparam int CNT_W = $clog2(DUR_W + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DUR_W-1:0]   quo_r, quo_nxt;
  logic [DVS_W-1:0]   rem_r, rem_nxt;
  logic [DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [DVS_W:0]     trial;
  logic [DVS_W:0]     diff;
  logic               ge;

  // one quotient bit per cycle, dividend shifts out as quotient shifts in
  always_comb begin
    trial    = {rem_r, quo_r[DUR_W-1]};
    ge       = trial >= {1'b0, dvs_r};
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DUR_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DUR_W-2:0], ge};
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### hw/rtl/ski_lane.sv
module ski_lane #(
  parameter logic [ski_pkg::ANGLE_W-1:0] RESET_ANGLE = ski_pkg::RESET_ANGLES[0]
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ski_pkg::lane_ctl_t          ctl,
  output logic [ski_pkg::ANGLE_W-1:0] angle
);
  import ski_pkg::*;

  logic [ANGLE_W-1:0] cur_r, cur_nxt;
  logic [ANGLE_W-1:0] q0_r, q0_nxt;
  logic [TICK_W-1:0]  r0_r, r0_nxt;
  logic [TICK_W-1:0]  r_r, r_nxt;
  logic               neg_r, neg_nxt;
  logic [TICK_W:0]    rsum;
  logic               carry;
  logic [ANGLE_W-1:0] inc;

  // quotient j*m/n tracked as running q0 steps plus remainder carry
  always_comb begin
    rsum    = {1'b0, r_r} + {1'b0, r0_r};
    carry   = rsum >= {1'b0, ctl.n};
    inc     = q0_r + ANGLE_W'(carry);
    cur_nxt = cur_r;
    q0_nxt  = q0_r;
    r0_nxt  = r0_r;
    r_nxt   = r_r;
    neg_nxt = neg_r;
    if (ctl.load) begin
      q0_nxt  = ctl.q0;
      r0_nxt  = ctl.r0;
      neg_nxt = ctl.neg;
      r_nxt   = '0;
    end else if (ctl.step) begin
      r_nxt   = carry ? TICK_W'(rsum - {1'b0, ctl.n}) : rsum[TICK_W-1:0];
      cur_nxt = neg_r ? cur_r - inc : cur_r + inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= RESET_ANGLE;
    end else begin
      cur_r <= cur_nxt;
    end
    q0_r  <= q0_nxt;
    r0_r  <= r0_nxt;
    r_r   <= r_nxt;
    neg_r <= neg_nxt;
  end

  assign angle = cur_r;

endmodule

### hw/rtl/servo_keyframe_interpolator.sv
// servo_keyframe_interpolator
// Linear keyframe interpolation for up to eight servos.
// Input channel (in_valid/in_ready): one keyframe item with eight target
// angles, a duration in ms and a final-keyframe flag. Output channel
// (out_valid/out_ready): one angle vector per tick, with last_tick and
// program_done flags. Config port (cfg_we/cfg_index/cfg_wdata): signed
// per-servo offsets, write while idle; indexes past the last servo ignored.
// After an item is taken the tick count is found by a bit-serial divider,
// then each active servo gets its step and remainder from the same divider,
// and after that the first tick is offered. Ticks then leave at one per cycle
// while out_ready is high; a stall holds the vector in its register.
// in_ready is high only between keyframes; a keyframe with zero ticks
// gives no items and returns to idle after the first divide.
// Reset clears offsets to zero and sets the servo angles to their home
// positions 135,45,135,45,45,135,45,135.
module servo_keyframe_interpolator #(
  parameter int TICK_PERIOD_MS = ski_pkg::TICK_PERIOD_MS_DEF,
  parameter int SERVO_COUNT    = ski_pkg::SERVO_COUNT_DEF,
  parameter int MAX_TICKS      = ski_pkg::MAX_TICKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ski_pkg::ANGLE_W-1:0]    in_target_zero,
  input  logic [ski_pkg::ANGLE_W-1:0]    in_target_one,
  input  logic [ski_pkg::ANGLE_W-1:0]    in_target_two,
  input  logic [ski_pkg::ANGLE_W-1:0]    in_target_three,
  input  logic [ski_pkg::ANGLE_W-1:0]    in_target_four,
  input  logic [ski_pkg::ANGLE_W-1:0]    in_target_five,
  input  logic [ski_pkg::ANGLE_W-1:0]    in_target_six,
  input  logic [ski_pkg::ANGLE_W-1:0]    in_target_seven,
  input  logic [ski_pkg::DUR_W-1:0]      in_duration_ms,
  input  logic                           in_final_keyframe,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ski_pkg::ANGLE_W-1:0]    out_angle_zero,
  output logic [ski_pkg::ANGLE_W-1:0]    out_angle_one,
  output logic [ski_pkg::ANGLE_W-1:0]    out_angle_two,
  output logic [ski_pkg::ANGLE_W-1:0]    out_angle_three,
  output logic [ski_pkg::ANGLE_W-1:0]    out_angle_four,
  output logic [ski_pkg::ANGLE_W-1:0]    out_angle_five,
  output logic [ski_pkg::ANGLE_W-1:0]    out_angle_six,
  output logic [ski_pkg::ANGLE_W-1:0]    out_angle_seven,
  output logic                           out_last_tick,
  output logic                           out_program_done,
  input  logic                           cfg_we,
  input  logic [ski_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ski_pkg::OFFS_W-1:0]     cfg_wdata
);
  import ski_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NDIV,
    ST_LSTART,
    ST_LWAIT,
    ST_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [OFFS_W-1:0]    offs_r [NUM_CH];
  logic [ANGLE_W-1:0]   tgt_r [NUM_CH];
  logic [ANGLE_W-1:0]   tgt_nxt [NUM_CH];
  logic                 fin_r, fin_nxt;
  logic [TICK_W-1:0]    n_r, n_nxt;
  logic [TICK_W-1:0]    j_r, j_nxt;
  logic [SRV_IDX_W-1:0] idx_r, idx_nxt;
  logic                 neg_r, neg_nxt;

  logic [ANGLE_W-1:0]   angle [NUM_CH];
  lane_ctl_t            lane_ctl [NUM_CH];

  logic                 in_acc;
  logic                 out_acc;
  logic                 last;
  logic                 div_start;
  logic [DUR_W-1:0]     div_dvd;
  logic [DVS_W-1:0]     div_dvs;
  logic                 div_done;
  logic [DUR_W-1:0]     div_quo;
  logic [DVS_W-1:0]     div_rem;
  logic                 lane_load;
  logic                 lane_step;
  logic signed [GOAL_W-1:0] gsum;
  logic signed [GOAL_W-1:0] goal;
  logic signed [GOAL_W-1:0] delta;
  logic [ANGLE_W-1:0]   mag;
  logic                 dneg;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign last      = ({1'b0, j_r} + (TICK_W + 1)'(1)) == {1'b0, n_r};

  // goal and signed distance for the servo being set up
  always_comb begin
    gsum = $signed({2'b00, tgt_r[idx_r]})
         + $signed({{(GOAL_W - OFFS_W){offs_r[idx_r][OFFS_W-1]}}, offs_r[idx_r]});
    if (gsum < 0) begin
      goal = '0;
    end else if (gsum > GOAL_W'(ANGLE_MAX)) begin
      goal = GOAL_W'(ANGLE_MAX);
    end else begin
      goal = gsum;
    end
    delta = goal - $signed({2'b00, angle[idx_r]});
    dneg  = delta < 0;
    mag   = dneg ? ANGLE_W'(-delta) : ANGLE_W'(delta);
  end

  always_comb begin
    div_start = in_acc || (state_r == ST_LSTART);
    div_dvd   = (state_r == ST_IDLE) ? in_duration_ms : DUR_W'(mag);
    div_dvs   = (state_r == ST_IDLE) ? DVS_W'(TICK_PERIOD_MS) : DVS_W'(n_r);
  end

  ski_serdiv u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    n_nxt     = n_r;
    j_nxt     = j_r;
    idx_nxt   = idx_r;
    neg_nxt   = neg_r;
    lane_load = 1'b0;
    lane_step = 1'b0;
    for (int k = 0; k < NUM_CH; k++) begin
      tgt_nxt[k] = tgt_r[k];
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          tgt_nxt[0] = in_target_zero;
          tgt_nxt[1] = in_target_one;
          tgt_nxt[2] = in_target_two;
          tgt_nxt[3] = in_target_three;
          tgt_nxt[4] = in_target_four;
          tgt_nxt[5] = in_target_five;
          tgt_nxt[6] = in_target_six;
          tgt_nxt[7] = in_target_seven;
          fin_nxt    = in_final_keyframe;
          state_nxt  = ST_NDIV;
        end
      end
      ST_NDIV: begin
        if (div_done) begin
          if (div_quo > DUR_W'(MAX_TICKS)) begin
            n_nxt = TICK_W'(MAX_TICKS);
          end else begin
            n_nxt = div_quo[TICK_W-1:0];
          end
          idx_nxt   = '0;
          j_nxt     = '0;
          state_nxt = (div_quo == '0) ? ST_IDLE : ST_LSTART;
        end
      end
      ST_LSTART: begin
        neg_nxt   = dneg;
        state_nxt = ST_LWAIT;
      end
      ST_LWAIT: begin
        if (div_done) begin
          lane_load = 1'b1;
          if (idx_r == SRV_IDX_W'(SERVO_COUNT - 1)) begin
            state_nxt = ST_EMIT;
          end else begin
            idx_nxt   = idx_r + SRV_IDX_W'(1);
            state_nxt = ST_LSTART;
          end
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (last) begin
            state_nxt = ST_IDLE;
          end else begin
            lane_step = 1'b1;
            j_nxt     = j_r + TICK_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int k = 0; k < NUM_CH; k++) begin
        offs_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_CH))) begin
        offs_r[cfg_index[SRV_IDX_W-1:0]] <= cfg_wdata;
      end
    end
    for (int k = 0; k < NUM_CH; k++) begin
      tgt_r[k] <= tgt_nxt[k];
    end
    fin_r <= fin_nxt;
    n_r   <= n_nxt;
    j_r   <= j_nxt;
    idx_r <= idx_nxt;
    neg_r <= neg_nxt;
  end

  for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
    if (k < SERVO_COUNT) begin : g_act
      always_comb begin
        lane_ctl[k].load = lane_load && (idx_r == SRV_IDX_W'(k));
        lane_ctl[k].step = lane_step;
        lane_ctl[k].neg  = neg_r;
        lane_ctl[k].q0   = div_quo[ANGLE_W-1:0];
        lane_ctl[k].r0   = div_rem[TICK_W-1:0];
        lane_ctl[k].n    = n_r;
      end
      ski_lane #(
        .RESET_ANGLE (RESET_ANGLES[k])
      ) u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (lane_ctl[k]),
        .angle (angle[k])
      );
    end else begin : g_idle
      assign lane_ctl[k] = '0;
      assign angle[k]    = lane_ctl[k].load ? '0 : RESET_ANGLES[k];
    end
  end

  assign out_angle_zero   = angle[0];
  assign out_angle_one    = angle[1];
  assign out_angle_two    = angle[2];
  assign out_angle_three  = angle[3];
  assign out_angle_four   = angle[4];
  assign out_angle_five   = angle[5];
  assign out_angle_six    = angle[6];
  assign out_angle_seven  = angle[7];
  assign out_last_tick    = last;
  assign out_program_done = last && fin_r;

endmodule
